FILE: hdl/nct_pkg.sv
// ----------------------------------------------------------------------------
// nct_pkg
// Shared constants, phase codes and byte classifiers for the token checker.
// ----------------------------------------------------------------------------
package nct_pkg;

  localparam int CHAR_W  = 8;
  localparam int MODE_W  = 3;
  localparam int PHASE_W = 4;
  localparam int MASK_W  = 64;
  localparam int NUM_MASK = 4;
  localparam int MASK_IDX_W = $clog2(NUM_MASK);
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = MASK_IDX_W + 3;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [MASK_W-1:0]  mask_t;

  localparam mode_t MODE_INT         = 3'd0;
  localparam mode_t MODE_INT_DELIM   = 3'd1;
  localparam mode_t MODE_FLOAT       = 3'd2;
  localparam mode_t MODE_FLOAT_DELIM = 3'd3;
  localparam mode_t MODE_NAME        = 3'd4;

  localparam phase_t PH_LEAD  = 4'd0;
  localparam phase_t PH_ISIGN = 4'd1;
  localparam phase_t PH_IDIG  = 4'd2;
  localparam phase_t PH_FINT  = 4'd3;
  localparam phase_t PH_FFRAC = 4'd4;
  localparam phase_t PH_EWS   = 4'd5;
  localparam phase_t PH_ESIGN = 4'd6;
  localparam phase_t PH_EDIG  = 4'd7;
  localparam phase_t PH_NBODY = 4'd8;

  localparam char_t CH_SPACE = 8'd32;
  localparam char_t CH_TAB   = 8'd9;
  localparam char_t CH_LF    = 8'd10;
  localparam char_t CH_FF    = 8'd12;
  localparam char_t CH_CR    = 8'd13;
  localparam char_t CH_PLUS  = 8'd43;
  localparam char_t CH_MINUS = 8'd45;
  localparam char_t CH_DOT   = 8'd46;
  localparam char_t CH_ZERO  = 8'd48;
  localparam char_t CH_NINE  = 8'd57;
  localparam char_t CH_UPR_A = 8'd65;
  localparam char_t CH_UPR_Z = 8'd90;
  localparam char_t CH_LWR_A = 8'd97;
  localparam char_t CH_LWR_Z = 8'd122;
  localparam char_t CH_UPR_E = 8'd69;
  localparam char_t CH_LWR_E = 8'd101;
  localparam char_t CH_UNDER = 8'd95;
  localparam char_t CH_PRT_LO = 8'd33;
  localparam char_t CH_PRT_HI = 8'd126;

  function automatic logic is_ws(char_t c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic is_dig(char_t c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_alpha(char_t c);
    return (c >= CH_UPR_A && c <= CH_UPR_Z) || (c >= CH_LWR_A && c <= CH_LWR_Z);
  endfunction

  function automatic logic is_sign(char_t c);
    return c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic logic is_exp(char_t c);
    return c == CH_UPR_E || c == CH_LWR_E;
  endfunction

  function automatic logic is_print(char_t c);
    return c >= CH_PRT_LO && c <= CH_PRT_HI;
  endfunction

endpackage

FILE: hdl/nct_if.sv
// ----------------------------------------------------------------------------
// nct_if
// Valid/ready channels for token bytes in and check results out.
// ----------------------------------------------------------------------------
interface nct_in_if;
  logic                 valid;
  logic                 ready;
  nct_pkg::char_t       character;
  logic                 end_of_text;
  nct_pkg::mode_t       mode;

  modport source (output valid, output character, output end_of_text, output mode,
                  input ready);
  modport sink   (input valid, input character, input end_of_text, input mode,
                  output ready);
endinterface

interface nct_out_if;
  logic valid;
  logic ready;
  logic is_valid;

  modport source (output valid, output is_valid, input ready);
  modport sink   (input valid, input is_valid, output ready);
endinterface

FILE: hdl/number_and_name_token_checker.sv
// ----------------------------------------------------------------------------
// number_and_name_token_checker
// Checks numeric literal and name tokens streamed one byte per beat.
//
// Input channel carries one byte per beat plus an end_of_text marker; the
// mode is sampled on the first beat of each token. Every beat updates the
// token state in the cycle it is accepted, so one beat is taken per cycle
// while in.ready is high. Only an end_of_text beat produces an output beat,
// which is presented from the result register in the cycle after acceptance.
// The result register frees in the cycle it is taken, so a stream of
// end_of_text beats still runs at one per cycle while out.ready is high;
// in.ready drops only while a result is held and out.ready is low.
// The four 64-bit delimiter masks sit on the APB port at byte offsets 0, 8,
// 16 and 24; the user writes them while no token is in flight (not enforced).
// Synchronous reset clears token state, the masks and the result valid flag.
// ----------------------------------------------------------------------------
module number_and_name_token_checker (
  input  logic                          clk,
  input  logic                          rst,
  nct_in_if.sink                        in_ch,
  nct_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nct_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nct_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nct_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import nct_pkg::*;

  mask_t                delim_mask [NUM_MASK];
  logic [MASK_IDX_W-1:0] reg_idx;

  phase_t phase, phase_next;
  mode_t  held_mode, held_mode_next;
  logic   at_token_start, at_token_start_next;
  logic   verdict_fixed, verdict_fixed_next;
  logic   verdict, verdict_next;
  logic   mantissa_digit_seen, mantissa_digit_seen_next;

  logic   res_valid;
  logic   res_is_valid;
  logic   accept;
  logic   end_ok;
  logic   member;
  logic   delimited;
  mode_t  mode_eff;
  char_t  c;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign prdata  = delim_mask[reg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MASK; i++) begin
        delim_mask[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      delim_mask[reg_idx] <= pwdata;
    end
  end

  assign in_ch.ready = !res_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.character;
  assign mode_eff    = at_token_start ? in_ch.mode : held_mode;
  assign delimited   = mode_eff == MODE_INT_DELIM || mode_eff == MODE_FLOAT_DELIM;
  assign member      = delim_mask[c[7:6]][c[5:0]];

  always_comb begin
    if (verdict_fixed) begin
      end_ok = verdict;
    end else begin
      unique case (mode_eff)
        MODE_INT, MODE_INT_DELIM: end_ok = phase == PH_IDIG;
        MODE_FLOAT, MODE_FLOAT_DELIM: begin
          if (phase == PH_FINT || phase == PH_FFRAC) end_ok = mantissa_digit_seen;
          else end_ok = phase == PH_EDIG;
        end
        MODE_NAME: end_ok = phase == PH_NBODY;
        default:   end_ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    phase_next               = phase;
    held_mode_next           = held_mode;
    at_token_start_next      = at_token_start;
    verdict_fixed_next       = verdict_fixed;
    verdict_next             = verdict;
    mantissa_digit_seen_next = mantissa_digit_seen;
    if (accept) begin
      held_mode_next      = mode_eff;
      at_token_start_next = 1'b0;
      if (in_ch.end_of_text) begin
        phase_next               = PH_LEAD;
        at_token_start_next      = 1'b1;
        verdict_fixed_next       = 1'b0;
        verdict_next             = 1'b0;
        mantissa_digit_seen_next = 1'b0;
      end else if (!verdict_fixed) begin
        unique case (mode_eff)
          MODE_INT, MODE_INT_DELIM: begin
            priority if (phase == PH_LEAD) begin
              priority if (is_ws(c)) phase_next = phase;
              else if (is_sign(c)) phase_next = PH_ISIGN;
              else if (is_dig(c)) phase_next = PH_IDIG;
              else verdict_fixed_next = 1'b1;
            end else if (phase == PH_ISIGN) begin
              if (is_dig(c)) phase_next = PH_IDIG;
              else verdict_fixed_next = 1'b1;
            end else if (phase == PH_IDIG) begin
              if (!is_dig(c)) begin
                verdict_fixed_next = 1'b1;
                verdict_next       = delimited && member;
              end
            end else begin
              verdict_fixed_next = 1'b1;
            end
          end
          MODE_FLOAT, MODE_FLOAT_DELIM: begin
            priority if (phase == PH_LEAD) begin
              priority if (is_ws(c)) phase_next = phase;
              else if (is_sign(c)) phase_next = PH_FINT;
              else if (is_dig(c)) begin
                mantissa_digit_seen_next = 1'b1;
                phase_next               = PH_FINT;
              end else if (c == CH_DOT) phase_next = PH_FFRAC;
              else verdict_fixed_next = 1'b1;
            end else if (phase == PH_FINT || phase == PH_FFRAC) begin
              priority if (is_dig(c)) mantissa_digit_seen_next = 1'b1;
              else if (c == CH_DOT && phase == PH_FINT) phase_next = PH_FFRAC;
              else if (!mantissa_digit_seen) verdict_fixed_next = 1'b1;
              else if (is_exp(c)) phase_next = PH_EWS;
              else begin
                verdict_fixed_next = 1'b1;
                verdict_next       = delimited && member;
              end
            end else if (phase == PH_EWS) begin
              priority if (is_ws(c)) phase_next = phase;
              else if (is_sign(c)) phase_next = PH_ESIGN;
              else if (is_dig(c)) phase_next = PH_EDIG;
              else verdict_fixed_next = 1'b1;
            end else if (phase == PH_ESIGN) begin
              if (is_dig(c)) phase_next = PH_EDIG;
              else verdict_fixed_next = 1'b1;
            end else if (phase == PH_EDIG) begin
              if (!is_dig(c)) begin
                verdict_fixed_next = 1'b1;
                verdict_next       = delimited && member;
              end
            end else begin
              verdict_fixed_next = 1'b1;
            end
          end
          MODE_NAME: begin
            priority if (phase == PH_LEAD) begin
              priority if (c == CH_UNDER) phase_next = phase;
              else if (is_alpha(c)) phase_next = PH_NBODY;
              else verdict_fixed_next = 1'b1;
            end else if (phase == PH_NBODY && is_print(c)) begin
              phase_next = phase;
            end else begin
              verdict_fixed_next = 1'b1;
            end
          end
          default: verdict_fixed_next = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_LEAD;
      held_mode           <= MODE_INT;
      at_token_start      <= 1'b1;
      verdict_fixed       <= 1'b0;
      verdict             <= 1'b0;
      mantissa_digit_seen <= 1'b0;
      res_valid           <= 1'b0;
    end else begin
      phase               <= phase_next;
      held_mode           <= held_mode_next;
      at_token_start      <= at_token_start_next;
      verdict_fixed       <= verdict_fixed_next;
      verdict             <= verdict_next;
      mantissa_digit_seen <= mantissa_digit_seen_next;
      if (accept && in_ch.end_of_text) res_valid <= 1'b1;
      else if (out_ch.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.end_of_text) res_is_valid <= end_ok;
  end

  assign out_ch.valid    = res_valid;
  assign out_ch.is_valid = res_is_valid;

endmodule

FILE: hdl/nct_checker.sv
// ----------------------------------------------------------------------------
// nct_checker
// Port-level checks for the token checker, bound to the top level.
// ----------------------------------------------------------------------------
module nct_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_end_of_text,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_valid
);

  // stalled result beat stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_is_valid))
    else $error("stalled result beat changed");

  // a fresh result only follows an accepted end-of-text beat
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_end_of_text))
    else $error("result without end of text");

  // back-to-back results need an end-of-text accept each time
  assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid && out_ready) |->
      $past(in_valid && in_ready && in_end_of_text))
    else $error("result repeated");

  // input stalls only behind a held result
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without cause");

  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind number_and_name_token_checker nct_checker u_nct_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_end_of_text (in_ch.end_of_text),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_is_valid   (out_ch.is_valid)
);
